/* sv/keyword_score_top_k_top_macros.svh */
// assertion helpers for the top-k selector
`ifndef KEYWORD_SCORE_TOP_K_TOP_MACROS_SVH
`define KEYWORD_SCORE_TOP_K_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define KST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define KST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KST_ASSERT_NOW(label, ante, cons)
`define KST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/kst_pkg.sv */
package kst_pkg;

    localparam int ID_W           = 32;
    localparam int SCORE_W        = 9;
    localparam int HITS_W         = 7;
    localparam int KEEP_W         = 5;
    localparam int RANK_W         = 4;
    localparam int FOUND_W        = 5;
    localparam int MAX_KEPT_DEF   = 16;
    localparam int MAX_TOKENS_DEF = 96;
    localparam int TOK_W          = 8;
    localparam int SUM_W          = 11;

    localparam logic [KEEP_W-1:0]  KEEP_RESET = 5'd8;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 9'd511;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // score = 2*text + 3*keyword, hit counts clipped first, score clipped to 9 bits
    function automatic logic [SCORE_W-1:0] calc_score(
        input logic [HITS_W-1:0] text_hits,
        input logic [HITS_W-1:0] keyword_hits,
        input logic [TOK_W-1:0]  tok_cap
    );
        logic [TOK_W-1:0] th;
        logic [TOK_W-1:0] kh;
        logic [SUM_W-1:0] sum;
        th = ({1'b0, text_hits} > tok_cap) ? tok_cap : {1'b0, text_hits};
        kh = ({1'b0, keyword_hits} > tok_cap) ? tok_cap : {1'b0, keyword_hits};
        sum = {th, 1'b0} + {2'b00, kh, 1'b0} + {3'b000, kh};
        if (sum > {2'b00, SCORE_MAX}) begin
            calc_score = SCORE_MAX;
        end else begin
            calc_score = sum[SCORE_W-1:0];
        end
    endfunction

endpackage

/* sv/keyword_score_top_k_top.sv */
// one chunk item is accepted per cycle while idle; its insertion completes at the accepting edge
// after an item with last_chunk set, the state register moves to emit and results leave through output registers,
// one per cycle from the head of the cell chain, found_count results (one for an empty list)
// busy is high while the state is emit, until the final result is taken; the next item can be accepted
// once busy has dropped, and the receiver cannot stall results
// synchronous active-low reset empties the list and sets keep_count to 8
module keyword_score_top_k_top #(
    parameter int MAX_KEPT   = kst_pkg::MAX_KEPT_DEF,
    parameter int MAX_TOKENS = kst_pkg::MAX_TOKENS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [kst_pkg::ID_W-1:0]   i_chunk_id,
    input  logic [kst_pkg::HITS_W-1:0]    i_text_hits,
    input  logic [kst_pkg::HITS_W-1:0]    i_keyword_hits,
    input  logic                          i_last_chunk,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kst_pkg::KEEP_W-1:0]    i_cfg_data,
    output logic                          o_strobe,
    output logic signed [kst_pkg::ID_W-1:0]   o_entry_id,
    output logic [kst_pkg::SCORE_W-1:0]   o_entry_score,
    output logic [kst_pkg::RANK_W-1:0]    o_rank,
    output logic [kst_pkg::FOUND_W-1:0]   o_found_count,
    output logic                          o_list_empty,
    output logic                          o_last_result
);
    import kst_pkg::*;

    `include "keyword_score_top_k_top_macros.svh"

    localparam int TW = $clog2(MAX_KEPT + 1);
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [KEEP_W-1:0] r_keep;
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     n_total;
    logic [TW-1:0]     r_found;
    logic [TW-1:0]     n_found;
    logic [IW-1:0]     r_rank;
    logic [IW-1:0]     n_rank;

    logic                 r_strobe;
    logic                 n_strobe;
    logic [ID_W-1:0]      r_id;
    logic [ID_W-1:0]      n_id;
    logic [SCORE_W-1:0]   r_score;
    logic [SCORE_W-1:0]   n_score;
    logic [RANK_W-1:0]    r_rank_out;
    logic [RANK_W-1:0]    n_rank_out;
    logic [FOUND_W-1:0]   r_found_out;
    logic [FOUND_W-1:0]   n_found_out;
    logic                 r_empty;
    logic                 n_empty;
    logic                 r_last;
    logic                 n_last;

    t_entry              w_entry [MAX_KEPT];
    logic [MAX_KEPT-1:0] w_beat;
    t_cell_ctl           w_ctl;
    t_entry              w_new;
    logic                w_accept;
    logic [TW-1:0]       w_k;
    logic [TW-1:0]       w_k_m1;
    logic [TW-1:0]       w_total_eff;
    logic [TW-1:0]       w_new_total;
    logic                w_ins;
    logic                w_final;

    assign busy        = (r_state == ST_EMIT);
    assign o_cfg_ready = !busy;
    assign w_accept    = start && !busy;

    always_comb begin
        if (r_keep == '0) begin
            w_k = TW'(1);
        end else if (r_keep > MAX_KEPT) begin
            w_k = TW'(MAX_KEPT);
        end else begin
            w_k = TW'(r_keep);
        end
    end

    assign w_k_m1      = w_k - TW'(1);
    assign w_total_eff = (r_total > w_k) ? w_k : r_total;

    assign w_new.id    = $unsigned(i_chunk_id);
    assign w_new.score = calc_score(i_text_hits, i_keyword_hits, TOK_W'(MAX_TOKENS));

    // beats are monotone along the chain, so the cell at k-1 says whether it fits at all
    assign w_ins     = w_accept && (w_new.score != '0) && w_beat[w_k_m1[IW-1:0]];
    assign w_ctl.ins = w_ins;
    assign w_ctl.pop = (r_state == ST_EMIT) && (r_found != '0);

    always_comb begin
        if (w_ins) begin
            w_new_total = (w_total_eff == w_k) ? w_k : w_total_eff + TW'(1);
        end else begin
            w_new_total = w_total_eff;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEPT; gi++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_beat;
            logic   w_occ;

            if (gi == 0) begin : g_head
                assign w_prev      = '0;
                assign w_prev_beat = 1'b0;
            end else begin : g_body
                assign w_prev      = w_entry[gi-1];
                assign w_prev_beat = w_beat[gi-1];
            end

            if (gi == MAX_KEPT - 1) begin : g_tail
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            assign w_occ = (TW'(gi) < w_total_eff);

            kst_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_new       (w_new),
                .i_prev      (w_prev),
                .i_next      (w_next),
                .i_prev_beat (w_prev_beat),
                .i_occupied  (w_occ),
                .o_entry     (w_entry[gi]),
                .o_beat      (w_beat[gi])
            );
        end
    endgenerate

    assign w_final = (r_found == '0) || ((TW'(r_rank) + TW'(1)) == r_found);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_found     = r_found;
        n_rank      = r_rank;
        n_strobe    = 1'b0;
        n_id        = r_id;
        n_score     = r_score;
        n_rank_out  = r_rank_out;
        n_found_out = r_found_out;
        n_empty     = r_empty;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_total = w_new_total;
                    if (i_last_chunk) begin
                        n_state = ST_EMIT;
                        n_found = w_new_total;
                        n_rank  = '0;
                    end
                end
            end
            ST_EMIT: begin
                n_strobe    = 1'b1;
                n_rank_out  = RANK_W'(r_rank);
                n_found_out = FOUND_W'(r_found);
                n_last      = w_final;
                if (r_found == '0) begin
                    n_id    = '0;
                    n_score = '0;
                    n_empty = 1'b1;
                end else begin
                    n_id    = w_entry[0].id;
                    n_score = w_entry[0].score;
                    n_empty = 1'b0;
                end
                n_rank = r_rank + IW'(1);
                if (w_final) begin
                    n_state = ST_IDLE;
                    n_total = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_total  <= '0;
            r_keep   <= KEEP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_keep <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found     <= n_found;
        r_rank      <= n_rank;
        r_id        <= n_id;
        r_score     <= n_score;
        r_rank_out  <= n_rank_out;
        r_found_out <= n_found_out;
        r_empty     <= n_empty;
        r_last      <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_entry_id    = $signed(r_id);
    assign o_entry_score = r_score;
    assign o_rank        = r_rank_out;
    assign o_found_count = r_found_out;
    assign o_list_empty  = r_empty;
    assign o_last_result = r_last;

    `KST_ASSERT_NOW(a_total_bound, 1'b1, r_total <= TW'(MAX_KEPT))
    `KST_ASSERT_NOW(a_idle_after_last, o_strobe && o_last_result, !busy)
    `KST_ASSERT_NOW(a_empty_marker, o_strobe && o_list_empty, o_last_result && (o_found_count == '0))
    `KST_ASSERT_NEXT(a_rank_runs, o_strobe && !o_last_result, o_strobe && (o_rank == $past(o_rank) + 4'd1))
    `KST_ASSERT_NEXT(a_emit_starts, start && !busy && i_last_chunk, busy)

endmodule

/* sv/kst_cell.sv */
module kst_cell (
    input  logic               i_clk,
    input  kst_pkg::t_cell_ctl i_ctl,
    input  kst_pkg::t_entry    i_new,
    input  kst_pkg::t_entry    i_prev,
    input  kst_pkg::t_entry    i_next,
    input  logic               i_prev_beat,
    input  logic               i_occupied,
    output kst_pkg::t_entry    o_entry,
    output logic               o_beat
);
    import kst_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // strictly greater, so an equal score lands behind the older entry
    assign o_beat  = !i_occupied || (i_new.score > r_entry.score);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_beat) begin
                n_entry = i_prev;
            end else if (o_beat) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* tb/sv/keyword_score_top_k_top_test.sv */
`timescale 1ns / 1ps

module keyword_score_top_k_top_test;
    import kst_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_CHUNKS = 215;
    localparam int BURST_CHUNKS  = 40;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
        logic [FOUND_W-1:0] found;
        logic               empty;
        logic               last;
    } t_ranked;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ID_W-1:0]    i_chunk_id;
    logic [HITS_W-1:0]         i_text_hits;
    logic [HITS_W-1:0]         i_keyword_hits;
    logic                      i_last_chunk;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [KEEP_W-1:0]         i_cfg_data;
    logic                      o_strobe;
    logic signed [ID_W-1:0]    o_entry_id;
    logic [SCORE_W-1:0]        o_entry_score;
    logic [RANK_W-1:0]         o_rank;
    logic [FOUND_W-1:0]        o_found_count;
    logic                      o_list_empty;
    logic                      o_last_result;

    // mirror of the ranked list
    logic [ID_W-1:0]    list_ids    [MAX_KEPT_DEF];
    logic [SCORE_W-1:0] list_scores [MAX_KEPT_DEF];
    int                 list_total;
    logic [KEEP_W-1:0]  keep_reg;

    t_ranked ranked_out[$];

    int errors;
    int chunks_sent;
    int queries_done;
    int results_seen;
    int cycle_count;

    keyword_score_top_k_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_chunk_id     (i_chunk_id),
        .i_text_hits    (i_text_hits),
        .i_keyword_hits (i_keyword_hits),
        .i_last_chunk   (i_last_chunk),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_entry_id     (o_entry_id),
        .o_entry_score  (o_entry_score),
        .o_rank         (o_rank),
        .o_found_count  (o_found_count),
        .o_list_empty   (o_list_empty),
        .o_last_result  (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // scores one chunk into the mirrored list and queues the ranks it releases
    function automatic void rank_chunk(logic [ID_W-1:0] id, logic [HITS_W-1:0] th,
                                       logic [HITS_W-1:0] kh, logic last);
        int      k;
        int      pos;
        int      tc;
        int      kc;
        int      sc;
        int      j;
        t_ranked r;
        k = keep_reg;
        if (k < 1) k = 1;
        if (k > MAX_KEPT_DEF) k = MAX_KEPT_DEF;
        // a lowered keep count takes effect here
        if (list_total > k) list_total = k;
        tc = (th > MAX_TOKENS_DEF) ? MAX_TOKENS_DEF : th;
        kc = (kh > MAX_TOKENS_DEF) ? MAX_TOKENS_DEF : kh;
        sc = 2 * tc + 3 * kc;
        if (sc > SCORE_MAX) sc = SCORE_MAX;
        if (sc > 0) begin
            pos = list_total;
            for (j = 0; j < list_total; j++) begin
                if (sc > list_scores[j]) begin
                    pos = j;
                    break;
                end
            end
            if (pos < k) begin
                if (list_total < k) list_total++;
                for (j = list_total - 1; j > pos; j--) begin
                    list_ids[j]    = list_ids[j - 1];
                    list_scores[j] = list_scores[j - 1];
                end
                list_ids[pos]    = id;
                list_scores[pos] = SCORE_W'(sc);
            end
        end
        if (last) begin
            if (list_total == 0) begin
                r = '0;
                r.empty = 1'b1;
                r.last  = 1'b1;
                ranked_out.push_back(r);
            end else begin
                for (j = 0; j < list_total; j++) begin
                    r.id    = list_ids[j];
                    r.score = list_scores[j];
                    r.rank  = RANK_W'(j);
                    r.found = FOUND_W'(list_total);
                    r.empty = 1'b0;
                    r.last  = (j == list_total - 1);
                    ranked_out.push_back(r);
                end
            end
            list_total = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_ranked got;
        t_ranked want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            got.id    = o_entry_id;
            got.score = o_entry_score;
            got.rank  = o_rank;
            got.found = o_found_count;
            got.empty = o_list_empty;
            got.last  = o_last_result;
            if (ranked_out.size() == 0) begin
                $error("result with nothing outstanding: id %0d score %0d rank %0d",
                       got.id, got.score, got.rank);
                errors++;
            end else begin
                want = ranked_out.pop_front();
                check_field("entry_id", want.id, got.id);
                check_field("entry_score", want.score, got.score);
                check_field("rank", want.rank, got.rank);
                check_field("found_count", want.found, got.found);
                check_field("list_empty", want.empty, got.empty);
                check_field("last_result", want.last, got.last);
            end
        end
    end

    task automatic send_chunk(logic [ID_W-1:0] id, logic [HITS_W-1:0] th,
                              logic [HITS_W-1:0] kh, logic last);
        start          <= 1'b1;
        i_chunk_id     <= id;
        i_text_hits    <= th;
        i_keyword_hits <= kh;
        i_last_chunk   <= last;
        do @(posedge i_clk); while (busy);
        rank_chunk(id, th, kh, last);
        chunks_sent++;
        if (last) queries_done++;
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
    endtask

    // hold off until the list has been fully reported and the block is quiet
    task automatic drain();
        start <= 1'b0;
        while (ranked_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep(logic [KEEP_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        keep_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [HITS_W-1:0] pick_hits();
        case ($urandom_range(0, 5))
            0: return '0;
            // low counts give frequent ties
            1: return HITS_W'($urandom_range(0, 3));
            // around and above saturation
            2: return HITS_W'($urandom_range(94, 127));
            default: return HITS_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [KEEP_W-1:0] pick_keep();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 5'd31;
            2: return 5'd16;
            3: return 5'd1;
            4: return KEEP_W'($urandom_range(17, 31));
            default: return KEEP_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic run_query(int len, bit with_last, bit gaps);
        for (int n = 0; n < len; n++) begin
            if (gaps) maybe_gap();
            send_chunk($urandom, pick_hits(), pick_hits(), with_last && (n == len - 1));
        end
    endtask

    task automatic test_default_keep();
        // descending scores, the ninth beats nothing in a full list of eight
        for (int n = 0; n < 9; n++) begin
            maybe_gap();
            send_chunk(ID_W'(n + 1), HITS_W'(40 - 3 * n), '0, n == 8);
        end
    endtask

    task automatic test_empty_marker();
        send_chunk(32'h1234_5678, '0, '0, 1'b1);
    endtask

    task automatic test_extremes();
        write_keep(5'd31);
        send_chunk(32'h8000_0000, 7'd127, 7'd127, 1'b0);
        send_chunk(32'h7FFF_FFFF, 7'd96, 7'd0, 1'b0);
        send_chunk(32'hFFFF_FFFF, 7'd0, 7'd97, 1'b0);
        send_chunk(32'h0000_0000, 7'd1, 7'd0, 1'b0);
        // zero score on the last chunk is skipped before emission
        send_chunk(32'h5555_5555, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_ties_and_drop();
        write_keep(5'd2);
        send_chunk(32'd10, 7'd3, 7'd0, 1'b0);
        send_chunk(32'd11, 7'd0, 7'd2, 1'b0);
        send_chunk(32'd12, 7'd0, 7'd1, 1'b0);
        send_chunk(32'd13, 7'd3, 7'd1, 1'b1);
        // zero keep count behaves as one
        write_keep(5'd0);
        send_chunk(32'd20, 7'd1, 7'd1, 1'b0);
        send_chunk(32'd21, 7'd1, 7'd1, 1'b1);
    endtask

    task automatic test_keep_lowered();
        write_keep(5'd16);
        send_chunk(32'd30, 7'd10, 7'd0, 1'b0);
        send_chunk(32'd31, 7'd20, 7'd0, 1'b0);
        send_chunk(32'd32, 7'd5, 7'd5, 1'b0);
        write_keep(5'd1);
        send_chunk(32'd33, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_random();
        int target;
        int len;
        target = chunks_sent + RANDOM_CHUNKS;
        while (chunks_sent < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
                0: begin
                    // partial query, then the keep count changes under a loaded list
                    run_query(len, 1'b0, 1'b1);
                    write_keep(pick_keep());
                end
                1, 2: begin
                    write_keep(pick_keep());
                    run_query(len, 1'b1, 1'b1);
                end
                3: begin
                    run_query(len, 1'b1, 1'b1);
                    drain();
                end
                default: run_query(len, 1'b1, 1'b1);
            endcase
        end
    endtask

    task automatic test_back_to_back();
        int target;
        target = chunks_sent + BURST_CHUNKS;
        write_keep(KEEP_W'($urandom_range(1, 16)));
        while (chunks_sent < target) run_query($urandom_range(1, 10), 1'b1, 1'b0);
    endtask

    initial begin
        errors       = 0;
        chunks_sent  = 0;
        queries_done = 0;
        results_seen = 0;
        list_total   = 0;
        keep_reg     = KEEP_RESET;
        for (int j = 0; j < MAX_KEPT_DEF; j++) begin
            list_ids[j]    = '0;
            list_scores[j] = '0;
        end
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_chunk_id     <= '0;
        i_text_hits    <= '0;
        i_keyword_hits <= '0;
        i_last_chunk   <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_keep();
        test_empty_marker();
        test_extremes();
        test_ties_and_drop();
        test_keep_lowered();
        test_random();
        test_back_to_back();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d chunk items over %0d queries, checked %0d ranked results",
                 chunks_sent, queries_done, results_seen);
        $display("keep counts 0 to 31, hit saturation, ties, full-list drops, empty lists");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/kst_pkg.sv
sv/kst_cell.sv
sv/keyword_score_top_k_top.sv
tb/sv/keyword_score_top_k_top_test.sv
